@@ src/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int WAYS_DEF         = 8;
    localparam int ADDR_BITS_DEF    = 64;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_STORE  = 2'd1,
        ACT_MODIFY = 2'd2,
        ACT_OTHER  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OUT_HIT            = 3'd0,
        OUT_MISS           = 3'd1,
        OUT_MISS_HIT       = 3'd2,
        OUT_MISS_EVICT     = 3'd3,
        OUT_MISS_EVICT_HIT = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] address;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [2:0]  way_used;
        logic [31:0] total_hits;
        logic [31:0] total_misses;
        logic [31:0] total_evictions;
    } out_beat_t;

endpackage

@@ src/set_assoc_cache_lru_sim_core.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_core
// Tag store of a set-associative cache with LRU replacement; reports
// hit / miss / fill / eviction per access and running totals.
// ----------------------------------------------------------------------------
//  channel  | signals                         | beat
//  ---------+---------------------------------+------------------------------
//  in       | in_valid, in_stall, in_data     | action + address
//  out      | out_valid, out_stall, out_data  | outcome, way, three totals
//  cfg      | cfg_valid, cfg_ready, cfg_index,| register index + write data
//           | cfg_data                        |
//
//  Each access reads the set row from the memory, compares and updates
//  it, and writes the updated row back to the set memory.
//  A new access is taken while the previous result waits in the output
//  register. After reset a clearing pass walks all 2^MAX_SET_BITS rows,
//  one per cycle with in_stall high. A stalled output holds the block
//  in its result cycle.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_core
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int WAYS         = WAYS_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  in_beat_t        in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output out_beat_t       out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [63:0]     cfg_data
);
    localparam int NSETS = 1 << MAX_SET_BITS;
    localparam int SW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RW    = $clog2(WAYS + 1);
    localparam int ROWW  = WAYS * (1 + RW);

    // row layout: per way one valid bit and a rank
    logic [ROWW-1:0]      row_mem [NSETS];
    logic [ADDR_BITS-1:0] tag_mem [NSETS][WAYS];
    logic [ROWW-1:0]      row_rd_reg;
    logic [ADDR_BITS-1:0] tag_rd_reg [WAYS];

    state_t state_reg, state_next;
    logic [SW:0]          clr_reg;
    logic [2:0]           set_bits_reg;
    logic [3:0]           block_bits_reg;
    logic [3:0]           ways_reg;
    logic                 modify_reg;
    logic [SW-1:0]        set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [31:0]          hits_reg, misses_reg, evicts_reg;
    logic [2:0]           outcome_reg;
    logic [2:0]           way_reg;
    logic                 out_valid_reg;
    out_beat_t            out_reg;

    // lookup results
    logic [ROWW-1:0]      row_wr;
    logic                 wr_en, tag_wr_en;
    logic [WW-1:0]        way_sel;
    logic [2:0]           outcome;
    logic                 hit, free_found;
    logic [RW-1:0]        act_ways;
    logic [ADDR_BITS-1:0] addr_cut;
    logic [3:0]           sb;
    logic [SW-1:0]        set_idx;
    logic [ADDR_BITS-1:0] tag_calc;

    always_comb
    begin
        addr_cut = in_data.address[ADDR_BITS-1:0];
        sb = ({1'b0, set_bits_reg} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                       : {1'b0, set_bits_reg};
        set_idx = SW'((addr_cut >> block_bits_reg) & ((ADDR_BITS'(1) << sb) - 1'b1));
        tag_calc = addr_cut >> (5'(sb) + 5'(block_bits_reg));
        if (ways_reg == 4'd0)
            act_ways = RW'(1);
        else if (32'(ways_reg) > WAYS)
            act_ways = RW'(WAYS);
        else
            act_ways = RW'(ways_reg);
    end

    always_comb
    begin
        logic [RW-1:0] rk [WAYS];
        logic          vl [WAYS];
        logic [RW-1:0] r;
        logic          done;
        for (int j = 0; j < WAYS; j++)
        begin
            vl[j] = row_rd_reg[j*(1+RW)+RW];
            rk[j] = row_rd_reg[j*(1+RW) +: RW];
        end
        hit = 1'b0;
        way_sel = '0;
        for (int j = 0; j < WAYS; j++)
            if (!hit && j < act_ways && vl[j] && tag_rd_reg[j] == tag_reg)
            begin
                hit = 1'b1;
                way_sel = WW'(j);
            end
        free_found = 1'b0;
        if (!hit)
        begin
            for (int j = 0; j < WAYS; j++)
                if (!free_found && j < act_ways && !vl[j])
                begin
                    free_found = 1'b1;
                    way_sel = WW'(j);
                end
            if (!free_found)
            begin
                way_sel = '0;
                for (int j = 1; j < WAYS; j++)
                    if (j < act_ways && rk[j] < rk[way_sel])
                        way_sel = WW'(j);
            end
        end
        done = 1'b0;
        r = rk[way_sel];
        for (int j = 0; j < WAYS; j++)
            if (j < act_ways && vl[j] && rk[j] > r)
                rk[j] = rk[j] - 1'b1;
        rk[way_sel] = act_ways;
        vl[way_sel] = 1'b1;
        for (int j = 0; j < WAYS; j++)
            row_wr[j*(1+RW) +: 1+RW] = {vl[j], rk[j]};
        if (hit)
            outcome = OUT_HIT;
        else if (free_found)
            outcome = modify_reg ? OUT_MISS_HIT : OUT_MISS;
        else
            outcome = modify_reg ? OUT_MISS_EVICT_HIT : OUT_MISS_EVICT;
        tag_wr_en = (state_reg == ST_LOOKUP) && !hit && !done;
        wr_en = (state_reg == ST_LOOKUP);
    end

    // set memory: read one row, write back the updated row
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            row_mem[clr_reg[SW-1:0]] <= '0;
        else if (wr_en)
            row_mem[set_reg] <= row_wr;
        row_rd_reg <= row_mem[set_idx];
        for (int j = 0; j < WAYS; j++)
        begin
            if (tag_wr_en && way_sel == WW'(j))
                tag_mem[set_reg][j] <= tag_reg;
            tag_rd_reg[j] <= tag_mem[set_idx][j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            set_bits_reg <= '0;
            block_bits_reg <= '0;
            ways_reg <= 4'd1;
            hits_reg <= '0;
            misses_reg <= '0;
            evicts_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SET_BITS:   set_bits_reg <= cfg_data[2:0];
                    CFG_BLOCK_BITS: block_bits_reg <= cfg_data[3:0];
                    CFG_WAYS:       ways_reg <= cfg_data[3:0];
                    default:        ;
                endcase
            end
            if (state_reg == ST_LOOKUP)
            begin
                hits_reg <= hits_reg + 32'(hit ? (modify_reg ? 2 : 1) : (modify_reg ? 1 : 0));
                misses_reg <= misses_reg + 32'(!hit);
                evicts_reg <= evicts_reg + 32'(!hit && !free_found);
            end
            if (state_reg == ST_OUT && state_next == ST_IDLE)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers; hold the result aside until the output beat frees up
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && !in_stall)
        begin
            modify_reg <= (in_data.action == ACT_MODIFY);
            set_reg <= set_idx;
            tag_reg <= tag_calc;
        end
        if (state_reg == ST_LOOKUP)
        begin
            outcome_reg <= outcome;
            way_reg <= 3'(way_sel);
        end
        if (state_reg == ST_OUT && state_next == ST_IDLE)
        begin
            out_reg.outcome <= outcome_reg;
            out_reg.way_used <= way_reg;
            out_reg.total_hits <= hits_reg;
            out_reg.total_misses <= misses_reg;
            out_reg.total_evictions <= evicts_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == (SW+1)'(NSETS - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_OUT;
            // hold until the output register frees up
            ST_OUT:    if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
